// ===== hdl/ddwb_pkg.sv =====
package ddwb_pkg;

    localparam int DABBLE_BITS = 4;

    localparam logic [1:0] FONT_WIDE   = 2'd0;
    localparam logic [1:0] FONT_NARROW = 2'd1;

    localparam logic [7:0] STEP_WIDE   = 8'd8;
    localparam logic [7:0] STEP_NARROW = 8'd6;

    localparam logic [5:0] CODE_SPACE = 6'd32;
    localparam logic [5:0] CODE_ZERO  = 6'd48;

    typedef struct packed {
        logic [2:0] count;
        logic [7:0] column;
        logic [2:0] page;
        logic       narrow;
    } side_t;

endpackage

// ===== hdl/ddwb_dabble_stage.sv =====
module ddwb_dabble_stage #(
    parameter int MAX_DIGITS = 5,
    parameter int PAD_BITS   = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [4*MAX_DIGITS-1:0] in_bcd,
    input  logic [PAD_BITS-1:0]     in_rest,
    input  ddwb_pkg::side_t         in_side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [4*MAX_DIGITS-1:0] out_bcd,
    output logic [PAD_BITS-1:0]     out_rest,
    output ddwb_pkg::side_t         out_side
);

    localparam int BCD_W = 4 * MAX_DIGITS;

    logic                valid_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_next;
    logic [PAD_BITS-1:0] rest_reg;
    logic [PAD_BITS-1:0] rest_next;
    ddwb_pkg::side_t     side_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_rest  = rest_reg;
    assign out_side  = side_reg;

    // add-3 then shift, DABBLE_BITS steps; digits above the top one fall off
    always_comb
    begin
        logic [BCD_W-1:0]    b;
        logic [PAD_BITS-1:0] r;
        b = in_bcd;
        r = in_rest;
        for (int s = 0; s < ddwb_pkg::DABBLE_BITS; s++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (b[4*d +: 4] >= 4'd5)
                begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], r[PAD_BITS-1]};
            r = {r[PAD_BITS-2:0], 1'b0};
        end
        bcd_next  = b;
        rest_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            bcd_reg  <= bcd_next;
            rest_reg <= rest_next;
            side_reg <= in_side;
        end
    end

endmodule

// ===== hdl/ddwb_serializer.sv =====
module ddwb_serializer #(
    parameter int MAX_DIGITS = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [4*MAX_DIGITS-1:0] in_bcd,
    input  ddwb_pkg::side_t         in_side,
    output logic                    strobe,
    output logic [7:0]              column,
    output logic [2:0]              page,
    output logic [5:0]              char_code,
    output logic                    last
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic             active_reg;
    logic [IDX_W-1:0] pos_reg;
    logic             shown_reg;
    logic [7:0]       col_reg;
    logic [7:0]       step_reg;
    logic [2:0]       page_reg;
    logic [3:0]       dig_reg [MAX_DIGITS];

    logic             strobe_reg;
    logic [7:0]       column_reg;
    logic [2:0]       page_out_reg;
    logic [5:0]       code_reg;
    logic             last_reg;

    logic [3:0]       digit;
    logic             at_last;
    logic             blank;
    logic             load;
    logic [5:0]       code_next;

    assign digit     = dig_reg[pos_reg];
    assign at_last   = (pos_reg == '0);
    assign blank     = !shown_reg && !at_last && (digit == 4'd0);
    assign code_next = blank ? ddwb_pkg::CODE_SPACE : ddwb_pkg::CODE_ZERO + {2'b00, digit};
    assign in_ready  = !active_reg || at_last;
    assign load      = in_valid && in_ready;

    assign strobe    = strobe_reg;
    assign column    = column_reg;
    assign page      = page_out_reg;
    assign char_code = code_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
            pos_reg    <= '0;
            shown_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
                pos_reg    <= IDX_W'(in_side.count - 3'd1);
                shown_reg  <= 1'b0;
            end
            else if (active_reg && at_last)
            begin
                active_reg <= 1'b0;
            end
            else if (active_reg)
            begin
                pos_reg   <= pos_reg - IDX_W'(1);
                shown_reg <= shown_reg || !blank;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg  <= in_side.column;
            step_reg <= in_side.narrow ? ddwb_pkg::STEP_NARROW : ddwb_pkg::STEP_WIDE;
            page_reg <= in_side.page;
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                dig_reg[d] <= in_bcd[4*d +: 4];
            end
        end
        else if (active_reg)
        begin
            col_reg <= col_reg + step_reg;
        end
        if (active_reg)
        begin
            column_reg   <= col_reg;
            page_out_reg <= page_reg;
            code_reg     <= code_next;
            last_reg     <= at_last;
        end
    end

endmodule

// ===== hdl/decimal_digits_with_blanking.sv =====
// channel  | handshake             | fields
// ---------+-----------------------+-----------------------------------------------
// input    | start high, busy low  | number, digit_count, start_column, page_row,
//          |                       | font_select
// result   | strobe, one cycle     | column, page, char_code, last
//
// A number enters a chain of NUMBER_BITS/4 (rounded up) conversion stages, then the
// character emitter, which registers the digits and then each character it sends.
// The emitter sends one character per cycle, digit_count characters for a number
// (clamped to MAX_DIGITS); a number that emits nothing is dropped at the input.
// busy rises when the emitter is still sending and every stage ahead of it is full.
// Reset clears valid bits and the strobe. The receiver cannot stall.
module decimal_digits_with_blanking #(
    parameter int MAX_DIGITS  = 5,
    parameter int NUMBER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [NUMBER_BITS-1:0] number,
    input  logic [2:0]             digit_count,
    input  logic [7:0]             start_column,
    input  logic [2:0]             page_row,
    input  logic [1:0]             font_select,
    output logic                   strobe,
    output logic [7:0]             column,
    output logic [2:0]             page,
    output logic [5:0]             char_code,
    output logic                   last
);

    localparam int STAGES   = (NUMBER_BITS + ddwb_pkg::DABBLE_BITS - 1) / ddwb_pkg::DABBLE_BITS;
    localparam int PAD_BITS = STAGES * ddwb_pkg::DABBLE_BITS;
    localparam int BCD_W    = 4 * MAX_DIGITS;
    localparam int MAX_EFF  = (MAX_DIGITS < 7) ? MAX_DIGITS : 7;

    logic                v     [STAGES+1];
    logic                rdy   [STAGES+1];
    logic [BCD_W-1:0]    bcd   [STAGES+1];
    logic [PAD_BITS-1:0] rest  [STAGES+1];
    ddwb_pkg::side_t     side  [STAGES+1];

    logic       nonempty;
    logic [2:0] count_clamped;

    assign count_clamped = (digit_count > 3'(MAX_EFF)) ? 3'(MAX_EFF) : digit_count;
    assign nonempty      = (digit_count != 3'd0) &&
                           (font_select == ddwb_pkg::FONT_WIDE ||
                            font_select == ddwb_pkg::FONT_NARROW);

    assign v[0]             = start && nonempty;
    assign bcd[0]           = '0;
    assign rest[0]          = PAD_BITS'(number);
    assign side[0].count    = count_clamped;
    assign side[0].column   = start_column;
    assign side[0].page     = page_row;
    assign side[0].narrow   = (font_select == ddwb_pkg::FONT_NARROW);
    assign busy             = !rdy[0];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        ddwb_dabble_stage #(
            .MAX_DIGITS (MAX_DIGITS),
            .PAD_BITS   (PAD_BITS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[k]),
            .in_ready  (rdy[k]),
            .in_bcd    (bcd[k]),
            .in_rest   (rest[k]),
            .in_side   (side[k]),
            .out_valid (v[k+1]),
            .out_ready (rdy[k+1]),
            .out_bcd   (bcd[k+1]),
            .out_rest  (rest[k+1]),
            .out_side  (side[k+1])
        );
    end

    ddwb_serializer #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v[STAGES]),
        .in_ready  (rdy[STAGES]),
        .in_bcd    (bcd[STAGES]),
        .in_side   (side[STAGES]),
        .strobe    (strobe),
        .column    (column),
        .page      (page),
        .char_code (char_code),
        .last      (last)
    );

endmodule

// ===== hdl/ddwb_checker.sv =====
module ddwb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic [7:0] column,
    input logic [2:0] page,
    input logic [5:0] char_code,
    input logic       last
);

    // characters of one word come out back to back
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a number");

    a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=>
            (column == 8'($past(column) + ddwb_pkg::STEP_WIDE)) ||
            (column == 8'($past(column) + ddwb_pkg::STEP_NARROW)))
        else $error("column step wrong");

    a_page_hold: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> page == $past(page))
        else $error("page changed inside a number");

    a_no_space_after_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last && char_code != ddwb_pkg::CODE_SPACE |=>
            char_code != ddwb_pkg::CODE_SPACE)
        else $error("blank after a shown digit");

    a_last_shown: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> char_code >= ddwb_pkg::CODE_ZERO &&
            char_code <= ddwb_pkg::CODE_ZERO + 6'd9)
        else $error("last character not a digit");

endmodule

bind decimal_digits_with_blanking ddwb_checker u_ddwb_checker (.*);

// ===== verif/decimal_digits_with_blanking_test.sv =====
`timescale 1ns / 1ps

localparam int          MAX_DIGITS     = 5;
localparam logic [1:0]  FONT_SPARE_TWO = 2'd2;
localparam logic [1:0]  FONT_SPARE_TRI = 2'd3;

typedef struct {
    logic [7:0] column;
    logic [2:0] page;
    logic [5:0] char_code;
    logic       last;
} char_t;

class char_scoreboard;
    char_t expected_chars[$];
    int    errors;
    int    words;
    int    silent;
    int    checked;

    function new();
        errors  = 0;
        words   = 0;
        silent  = 0;
        checked = 0;
    endfunction

    function void note_word(logic [15:0] num, logic [2:0] cnt, logic [7:0] col,
                            logic [2:0] pg, logic [1:0] font);
        int unsigned p;
        int unsigned digit;
        int          n_digits;
        logic [7:0]  step;
        bit          shown;
        bit          is_last;
        char_t       c;
        words++;
        if (font == ddwb_pkg::FONT_WIDE)
        begin
            step = ddwb_pkg::STEP_WIDE;
        end
        else if (font == ddwb_pkg::FONT_NARROW)
        begin
            step = ddwb_pkg::STEP_NARROW;
        end
        else
        begin
            silent++;
            return;
        end
        n_digits = (cnt > MAX_DIGITS) ? MAX_DIGITS : int'(cnt);
        if (n_digits == 0)
        begin
            silent++;
        end
        shown = 0;
        for (int i = 0; i < n_digits; i++)
        begin
            p = 1;
            for (int k = 0; k < n_digits - i - 1; k++)
            begin
                p = p * 10;
            end
            digit   = (int'(num) / p) % 10;
            is_last = (i + 1 == n_digits);
            if (!shown && !is_last && digit == 0)
            begin
                c.char_code = ddwb_pkg::CODE_SPACE;
            end
            else
            begin
                shown       = 1;
                c.char_code = ddwb_pkg::CODE_ZERO + 6'(digit);
            end
            c.column = col + 8'(int'(step) * i);
            c.page   = pg;
            c.last   = is_last;
            expected_chars.push_back(c);
        end
    endfunction

    function void check_char(logic [7:0] col, logic [2:0] pg, logic [5:0] code, logic lst);
        char_t want;
        if (expected_chars.size() == 0)
        begin
            $error("unexpected character: column %0d page %0d char_code %0d last %0d",
                   col, pg, code, lst);
            errors++;
            return;
        end
        want = expected_chars.pop_front();
        checked++;
        if (col !== want.column)
        begin
            $error("column: expected %0d, actual %0d", want.column, col);
            errors++;
        end
        if (pg !== want.page)
        begin
            $error("page: expected %0d, actual %0d", want.page, pg);
            errors++;
        end
        if (code !== want.char_code)
        begin
            $error("char_code: expected %0d, actual %0d", want.char_code, code);
            errors++;
        end
        if (lst !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, lst);
            errors++;
        end
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction
endclass

module decimal_digits_with_blanking_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 360;
    localparam int DRAIN_CYCLES  = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] number = '0;
    logic [2:0]  digit_count = '0;
    logic [7:0]  start_column = '0;
    logic [2:0]  page_row = '0;
    logic [1:0]  font_select = '0;
    logic        strobe;
    logic [7:0]  column;
    logic [2:0]  page;
    logic [5:0]  char_code;
    logic        last;

    char_scoreboard sb = new();
    int             cycles = 0;
    bit             idle_on = 1;

    decimal_digits_with_blanking i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .number       (number),
        .digit_count  (digit_count),
        .start_column (start_column),
        .page_row     (page_row),
        .font_select  (font_select),
        .strobe       (strobe),
        .column       (column),
        .page         (page),
        .char_code    (char_code),
        .last         (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycles, sb.pending());
            $display("decimal_digits_with_blanking_test: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            sb.check_char(column, page, char_code, last);
        end
    end

    // called right after an edge; returns right after the edge that accepts the word
    task automatic send_word(input logic [15:0] num, input logic [2:0] cnt,
                             input logic [7:0] col, input logic [2:0] pg,
                             input logic [1:0] font);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        number       <= num;
        digit_count  <= cnt;
        start_column <= col;
        page_row     <= pg;
        font_select  <= font;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        sb.note_word(num, cnt, col, pg, font);
    endtask

    // always waits on the clock before it checks for pending characters
    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
    endtask

    task automatic send_random_word();
        logic [15:0] num;
        logic [2:0]  cnt;
        logic [1:0]  font;
        case ($urandom_range(0, 3))
            0: num = 16'($urandom_range(0, 9));
            1: num = 16'($urandom_range(0, 999));
            2: num = 16'($urandom_range(0, 9999));
            default: num = 16'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 9) < 8)
        begin
            cnt = 3'($urandom_range(1, 5));
        end
        else
        begin
            cnt = 3'($urandom_range(0, 7));
        end
        if ($urandom_range(0, 9) < 9)
        begin
            font = $urandom_range(0, 1) ? ddwb_pkg::FONT_NARROW : ddwb_pkg::FONT_WIDE;
        end
        else
        begin
            font = $urandom_range(0, 1) ? FONT_SPARE_TRI : FONT_SPARE_TWO;
        end
        send_word(num, cnt, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), font);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(16'd0,     3'd5, 8'd0,   3'd0, ddwb_pkg::FONT_WIDE);
        send_word(16'd65535, 3'd5, 8'd255, 3'd7, ddwb_pkg::FONT_NARROW);
        send_word(16'd65535, 3'd3, 8'd10,  3'd1, ddwb_pkg::FONT_WIDE);
        send_word(16'd100,   3'd5, 8'd250, 3'd2, ddwb_pkg::FONT_WIDE);
        send_word(16'd10000, 3'd5, 8'd0,   3'd3, ddwb_pkg::FONT_NARROW);
        send_word(16'd7,     3'd1, 8'd128, 3'd4, ddwb_pkg::FONT_WIDE);
        send_word(16'd0,     3'd1, 8'd255, 3'd5, ddwb_pkg::FONT_NARROW);
        send_word(16'd12345, 3'd7, 8'd240, 3'd6, ddwb_pkg::FONT_WIDE);
        send_word(16'd12345, 3'd6, 8'd1,   3'd7, ddwb_pkg::FONT_NARROW);
        send_word(16'd999,   3'd0, 8'd20,  3'd1, ddwb_pkg::FONT_WIDE);
        send_word(16'd123,   3'd4, 8'd2,   3'd2, FONT_SPARE_TWO);
        send_word(16'd456,   3'd4, 8'd3,   3'd3, FONT_SPARE_TRI);
        send_word(16'd1,     3'd2, 8'd252, 3'd0, ddwb_pkg::FONT_NARROW);
        send_word(16'd1000,  3'd4, 8'd64,  3'd4, ddwb_pkg::FONT_WIDE);
        send_word(16'd5,     3'd2, 8'd90,  3'd5, ddwb_pkg::FONT_WIDE);
        send_word(16'd40000, 3'd4, 8'd170, 3'd6, ddwb_pkg::FONT_NARROW);
        send_word(16'd0,     3'd7, 8'd85,  3'd7, ddwb_pkg::FONT_NARROW);
        send_word(16'd9,     3'd0, 8'd0,   3'd0, FONT_SPARE_TRI);
        send_word(16'd50505, 3'd5, 8'd249, 3'd2, ddwb_pkg::FONT_WIDE);
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
            begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            if (n == RANDOM_WORDS / 2)
            begin
                drain();
            end
            send_random_word();
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d numbers sent (%0d silent), %0d characters checked",
                 sb.words, sb.silent, sb.checked);
        $display("fonts, counts 0-7, column wrap, blanking and idle gaps exercised");
        if (sb.errors == 0)
        begin
            $display("decimal_digits_with_blanking_test: clean");
        end
        else
        begin
            $display("decimal_digits_with_blanking_test: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ddwb_pkg.sv
hdl/ddwb_dabble_stage.sv
hdl/ddwb_serializer.sv
hdl/decimal_digits_with_blanking.sv
hdl/ddwb_checker.sv
verif/decimal_digits_with_blanking_test.sv
